### rtl/core/sscd_pkg.sv
`default_nettype none

package sscd_pkg;

    // Longest section that is still parsed; bytes beyond it spoil the section.
    localparam int MAX_SECTION_BYTES = 4096;
    localparam int POS_W             = $clog2(MAX_SECTION_BYTES + 1);
    // Common width for position and length arithmetic (position + 1 + 255).
    localparam int CMP_W             = 14;

    localparam int          WALK_START = 16;
    localparam int          MIN_LENGTH = 11;
    localparam logic [7:0]  DST_TAG    = 8'h96;
    localparam logic [7:0]  DST_LENGTH = 8'd2;

    localparam logic CFG_MATCH_ID = 1'b0;
    localparam logic CFG_NOTIFY   = 1'b1;

    typedef enum logic [2:0] {
        KIND_SEEN     = 3'd0,
        KIND_CHANGED  = 3'd1,
        KIND_TIME     = 3'd2,
        KIND_OFFSET   = 3'd3,
        KIND_DST      = 3'd4,
        KIND_COMPLETE = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // One finished section whose notices are still to be sent.
    typedef struct packed {
        logic        lead_changed;
        logic        has_time;
        logic        has_offset;
        logic        has_dst;
        logic [31:0] new_time;
        logic [7:0]  new_offset;
        logic [14:0] new_dst;
    } job_t;

    // Handshake between the parser, the job queue and the notice emitter.
    typedef struct packed {
        logic push;
        logic full;
    } front_ctl_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } back_ctl_t;

endpackage

`default_nettype wire

### rtl/core/sscd_if.sv
`default_nettype none

interface sscd_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, func, data_byte, last_byte, input ready);
    modport sink   (input valid, func, data_byte, last_byte, output ready);
endinterface

interface sscd_out_if;
    logic                valid;
    logic                ready;
    sscd_pkg::kind_t     kind;
    logic [31:0]         time_value;
    logic [7:0]          offset_value;
    logic                dst_known;
    logic                dst_active;
    logic [4:0]          dst_day;
    logic [7:0]          dst_hour;
    logic                final_notice;

    modport source (output valid, kind, time_value, offset_value, dst_known, dst_active,
                    dst_day, dst_hour, final_notice, input ready);
    modport sink   (input valid, kind, time_value, offset_value, dst_known, dst_active,
                    dst_day, dst_hour, final_notice, output ready);
endinterface

`default_nettype wire

### rtl/core/sscd_front.sv
`default_nettype none

module sscd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    sscd_in_if.sink                   byte_ch,
    input  wire logic                 cfg_write,
    input  wire logic                 cfg_index,
    input  wire logic [7:0]           cfg_data,
    output sscd_pkg::front_ctl_t      ctl,
    input  wire logic                 queue_full,
    output sscd_pkg::job_t            job
);

    localparam int PW = sscd_pkg::POS_W;
    localparam int CW = sscd_pkg::CMP_W;

    logic [7:0]  match_id_reg;
    logic        notify_reg;

    logic [PW-1:0]        pos_reg,    pos_next;
    logic [11:0]          len_reg,    len_next;
    logic                 bad_reg,    bad_next;
    sscd_pkg::phase_t     phase_reg,  phase_next;
    logic [7:0]           tag_reg,    tag_next;
    logic [7:0]           rem_reg,    rem_next;
    logic [7:0]           first_reg,  first_next;
    logic [31:0]          time_reg,   time_next;
    logic [7:0]           offset_reg, offset_next;
    logic [14:0]          dst_reg,    dst_next;
    logic [31:0]          s_time_reg,   s_time_next;
    logic [7:0]           s_offset_reg, s_offset_next;
    logic [14:0]          s_dst_reg,    s_dst_next;

    logic          accept;
    logic          overlong;
    logic [CW-1:0] pos_w;
    logic [CW-1:0] end_w;
    logic [7:0]    b;
    logic [7:0]    rem_dec;
    logic          fin_ok;
    logic          d_time;
    logic          d_offset;
    logic          d_dst;

    assign byte_ch.ready = !queue_full;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign b             = byte_ch.data_byte;
    assign pos_w         = CW'(pos_reg);
    assign end_w         = CW'(len_reg) - CW'(1);
    assign overlong      = pos_w >= CW'(sscd_pkg::MAX_SECTION_BYTES);
    assign rem_dec       = rem_reg - 8'd1;

    always_comb
    begin
        pos_next      = pos_reg;
        len_next      = len_reg;
        bad_next      = bad_reg;
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        rem_next      = rem_reg;
        first_next    = first_reg;
        time_next     = time_reg;
        offset_next   = offset_reg;
        dst_next      = dst_reg;
        s_time_next   = s_time_reg;
        s_offset_next = s_offset_reg;
        s_dst_next    = s_dst_reg;
        fin_ok        = 1'b0;
        d_time        = 1'b0;
        d_offset      = 1'b0;
        d_dst         = 1'b0;
        ctl.push      = 1'b0;
        ctl.full      = queue_full;

        if (accept && byte_ch.func)
        begin
            pos_next      = '0;
            len_next      = '0;
            bad_next      = 1'b0;
            phase_next    = sscd_pkg::PH_TAG;
            tag_next      = '0;
            rem_next      = '0;
            first_next    = '0;
            time_next     = '0;
            offset_next   = '0;
            dst_next      = '0;
            s_time_next   = '0;
            s_offset_next = '0;
            s_dst_next    = '0;
        end
        else if (accept)
        begin
            if (overlong)
            begin
                bad_next = 1'b1;
            end
            else if (!bad_reg)
            begin
                priority if (pos_w == CW'(0))
                begin
                    if (b != match_id_reg)
                        bad_next = 1'b1;
                end
                else if (pos_w == CW'(1))
                begin
                    if (b[7:6] != 2'b00)
                        bad_next = 1'b1;
                    len_next = {b[3:0], 8'h00};
                end
                else if (pos_w == CW'(2))
                begin
                    len_next = {len_reg[11:8], b};
                    if (len_next < 12'(sscd_pkg::MIN_LENGTH))
                        bad_next = 1'b1;
                end
                else if (pos_w == CW'(3))
                begin
                    if (b[4:0] != 5'd0)
                        bad_next = 1'b1;
                end
                else if (pos_w <= CW'(7))
                begin
                    time_next = {time_reg[23:0], b};
                end
                else if (pos_w == CW'(8))
                begin
                    offset_next = b;
                end
                else if (pos_w >= CW'(sscd_pkg::WALK_START) && pos_w < end_w)
                begin
                    // Descriptor walk between the fixed header and the CRC.
                    unique case (phase_reg)
                        sscd_pkg::PH_TAG:
                        begin
                            if (pos_w + CW'(1) < end_w)
                            begin
                                tag_next   = b;
                                phase_next = sscd_pkg::PH_LEN;
                            end
                        end
                        sscd_pkg::PH_LEN:
                        begin
                            rem_next = b;
                            if (pos_w + CW'(1) + CW'(b) > end_w)
                                bad_next = 1'b1;
                            else if (tag_reg == sscd_pkg::DST_TAG && b != sscd_pkg::DST_LENGTH)
                                bad_next = 1'b1;
                            else if (b == 8'd0)
                                phase_next = sscd_pkg::PH_TAG;
                            else
                                phase_next = sscd_pkg::PH_BODY;
                        end
                        sscd_pkg::PH_BODY:
                        begin
                            if (tag_reg == sscd_pkg::DST_TAG)
                            begin
                                if (rem_reg == 8'd2)
                                    first_next = b;
                                else if (rem_reg == 8'd1)
                                    dst_next = {1'b1, first_reg[7], first_reg[4:0], b};
                            end
                            rem_next = rem_dec;
                            if (rem_dec == 8'd0)
                                phase_next = sscd_pkg::PH_TAG;
                        end
                        default:
                        begin
                            phase_next = sscd_pkg::PH_TAG;
                        end
                    endcase
                end
            end

            if (!overlong)
                pos_next = pos_reg + PW'(1);

            if (byte_ch.last_byte)
            begin
                fin_ok = !bad_next && !overlong && (pos_w == CW'(len_next) + CW'(2));
                if (fin_ok)
                begin
                    d_time   = time_next != s_time_reg;
                    d_offset = offset_next != s_offset_reg;
                    d_dst    = dst_next[13:0] != s_dst_reg[13:0];
                    ctl.push = notify_reg && (d_time || d_offset || d_dst);
                    s_time_next   = time_next;
                    s_offset_next = offset_next;
                    s_dst_next    = dst_next;
                end
                pos_next    = '0;
                len_next    = '0;
                bad_next    = 1'b0;
                phase_next  = sscd_pkg::PH_TAG;
                tag_next    = '0;
                rem_next    = '0;
                first_next  = '0;
                time_next   = '0;
                offset_next = '0;
                dst_next    = '0;
            end
        end
    end

    // The job carries the values as they stood just before the parser was cleared.
    always_comb
    begin
        job.lead_changed = !(d_time && s_time_reg == 32'd0);
        job.has_time     = d_time;
        job.has_offset   = d_offset;
        job.has_dst      = d_dst;
        job.new_time     = s_time_next;
        job.new_offset   = s_offset_next;
        job.new_dst      = s_dst_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_id_reg <= 8'd197;
            notify_reg   <= 1'b1;
            pos_reg      <= '0;
            len_reg      <= '0;
            bad_reg      <= 1'b0;
            phase_reg    <= sscd_pkg::PH_TAG;
            tag_reg      <= '0;
            rem_reg      <= '0;
            first_reg    <= '0;
            time_reg     <= '0;
            offset_reg   <= '0;
            dst_reg      <= '0;
            s_time_reg   <= '0;
            s_offset_reg <= '0;
            s_dst_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    sscd_pkg::CFG_MATCH_ID: match_id_reg <= cfg_data;
                    sscd_pkg::CFG_NOTIFY:   notify_reg   <= cfg_data[0];
                    default:                notify_reg   <= notify_reg;
                endcase
            end
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            bad_reg      <= bad_next;
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            rem_reg      <= rem_next;
            first_reg    <= first_next;
            time_reg     <= time_next;
            offset_reg   <= offset_next;
            dst_reg      <= dst_next;
            s_time_reg   <= s_time_next;
            s_offset_reg <= s_offset_next;
            s_dst_reg    <= s_dst_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sscd_job_queue.sv
`default_nettype none

module sscd_job_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sscd_pkg::front_ctl_t front_ctl,
    input  wire sscd_pkg::job_t       push_job,
    output logic                      full,
    output sscd_pkg::back_ctl_t       back_ctl,
    input  wire logic                 pop,
    output sscd_pkg::job_t            head_job
);

    sscd_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg,  count_next;
    logic           do_push;
    logic           do_pop;

    assign full           = count_reg == 2'd2;
    assign back_ctl.empty = count_reg == 2'd0;
    assign back_ctl.pop   = do_pop;
    assign do_push        = front_ctl.push && !full;
    assign do_pop         = pop && !back_ctl.empty;
    assign head_job       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sscd_back.sv
`default_nettype none

module sscd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sscd_pkg::back_ctl_t  queue_ctl,
    input  wire sscd_pkg::job_t       head_job,
    output logic                      pop,
    sscd_out_if.source                notice_ch
);

    // Pending notices: lead, time, offset, daylight, complete.
    logic [4:0]      mask_reg,  mask_next;
    sscd_pkg::job_t  job_reg,   job_next;
    logic            valid_reg, valid_next;
    sscd_pkg::kind_t kind_reg,  kind_next;
    logic [31:0]     tval_reg,  tval_next;
    logic [7:0]      oval_reg,  oval_next;
    logic [14:0]     dval_reg,  dval_next;
    logic            final_reg, final_next;
    logic            slot_free;
    logic [4:0]      mask_left;

    assign slot_free = !valid_reg || notice_ch.ready;
    assign pop       = (mask_reg == 5'd0) && !queue_ctl.empty;

    always_comb
    begin
        mask_next  = mask_reg;
        job_next   = job_reg;
        valid_next = valid_reg && !notice_ch.ready;
        kind_next  = kind_reg;
        tval_next  = tval_reg;
        oval_next  = oval_reg;
        dval_next  = dval_reg;
        final_next = final_reg;
        mask_left  = mask_reg;

        if (pop)
        begin
            job_next  = head_job;
            mask_next = {1'b1, head_job.has_dst, head_job.has_offset, head_job.has_time, 1'b1};
        end
        else if (mask_reg != 5'd0 && slot_free)
        begin
            tval_next = '0;
            oval_next = '0;
            dval_next = '0;
            priority if (mask_reg[0])
            begin
                mask_left[0] = 1'b0;
                kind_next    = job_reg.lead_changed ? sscd_pkg::KIND_CHANGED
                                                    : sscd_pkg::KIND_SEEN;
            end
            else if (mask_reg[1])
            begin
                mask_left[1] = 1'b0;
                kind_next    = sscd_pkg::KIND_TIME;
                tval_next    = job_reg.new_time;
            end
            else if (mask_reg[2])
            begin
                mask_left[2] = 1'b0;
                kind_next    = sscd_pkg::KIND_OFFSET;
                oval_next    = job_reg.new_offset;
            end
            else if (mask_reg[3])
            begin
                mask_left[3] = 1'b0;
                kind_next    = sscd_pkg::KIND_DST;
                dval_next    = job_reg.new_dst;
            end
            else
            begin
                mask_left[4] = 1'b0;
                kind_next    = sscd_pkg::KIND_COMPLETE;
            end
            mask_next  = mask_left;
            valid_next = 1'b1;
            final_next = mask_left == 5'd0;
        end
    end

    assign notice_ch.valid        = valid_reg;
    assign notice_ch.kind         = kind_reg;
    assign notice_ch.time_value   = tval_reg;
    assign notice_ch.offset_value = oval_reg;
    assign notice_ch.dst_known    = dval_reg[14];
    assign notice_ch.dst_active   = dval_reg[13];
    assign notice_ch.dst_day      = dval_reg[12:8];
    assign notice_ch.dst_hour     = dval_reg[7:0];
    assign notice_ch.final_notice = final_reg;

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        kind_reg  <= kind_next;
        tval_reg  <= tval_next;
        oval_reg  <= oval_next;
        dval_reg  <= dval_next;
        final_reg <= final_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= 5'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/stt_section_change_detector_unit.sv
`default_nettype none

// Channel     Direction  Item
// byte_ch     in         func, data_byte, last_byte: one section byte or a clear command
// notice_ch   out        kind and values of one notice, final_notice on the last of a run
// cfg_*       in         write of the table id to match (index 0) or notify enable (index 1)
//
// Section bytes are taken at one per cycle; the parser holds all per-section state.
// A good section with changes queues one job if notify is enabled; a two-entry job queue
// sits between parser and emitter; the emitter fetches a job and sends up to five notices
// at one per cycle while notice_ch is ready. byte_ch stalls only while the queue is full.
// Reset clears the parser, the stored values and the queue, and loads the registers with
// table id 197 and notifications enabled; no clearing pass is needed.

module stt_section_change_detector_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sscd_in_if.sink          byte_ch,
    sscd_out_if.source       notice_ch,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    sscd_pkg::front_ctl_t front_ctl;
    sscd_pkg::back_ctl_t  back_ctl;
    sscd_pkg::job_t       push_job;
    sscd_pkg::job_t       head_job;
    logic                 queue_full;
    logic                 pop;

    // The parser checks the header, walks the descriptors and, at the last byte of a
    // good section, compares against the stored values and updates them at once.
    sscd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ctl        (front_ctl),
        .queue_full (queue_full),
        .job        (push_job)
    );

    // The queue lets the parser move on to the next section while notices drain.
    sscd_job_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .front_ctl (front_ctl),
        .push_job  (push_job),
        .full      (queue_full),
        .back_ctl  (back_ctl),
        .pop       (pop),
        .head_job  (head_job)
    );

    // The emitter expands one job into its notices through a registered output.
    sscd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .queue_ctl (back_ctl),
        .head_job  (head_job),
        .pop       (pop),
        .notice_ch (notice_ch)
    );

endmodule

`default_nettype wire

### sim/tb_stt_section_change_detector_unit.sv
`timescale 1ns / 100ps

module tb_stt_section_change_detector_unit;
    import sscd_pkg::*;

    // Run limits. The job queue is shallow and the emitter sends at most five notices per
    // section, so DRAIN_CYCLES is enough for the block to fall quiet.
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 24;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEM_TARGET    = 420;
    localparam int NOTICE_TARGET  = 48;
    localparam int PHASE_COUNT    = 5;
    localparam int OVERLONG_BYTES = MAX_SECTION_BYTES + 4;
    localparam int DIRECTED_ROWS  = 19;

    // Kinds of damage that the section builder can put into a section.
    typedef enum int {
        FL_NONE,
        FL_BAD_ID,
        FL_SYNTAX,
        FL_SHORT_LEN,
        FL_VERSION,
        FL_DST_LEN,
        FL_OVERRUN,
        FL_EARLY_END,
        FL_LATE_END,
        FL_COUNT
    } flaw_t;

    // One notice as it should leave the block.
    typedef struct {
        kind_t       kind;
        logic [31:0] tval;
        logic [7:0]  oval;
        logic        known;
        logic        active;
        logic [4:0]  day;
        logic [7:0]  hour;
        logic        fin;
    } notice_t;

    // One row of the directed table. A want_n of -1 means the row is left to the predictor.
    typedef struct {
        bit          func;
        logic [7:0]  data;
        bit          last;
        int          want_n;
        kind_t       want_first;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic cfg_index;
    logic [7:0] cfg_data;

    sscd_in_if  byte_if ();
    sscd_out_if notice_if ();

    stt_section_change_detector_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_if),
        .notice_ch (notice_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Directed part. The first section is the shortest legal one (length 11, so no room for
    // descriptors) with the system time and offset at their maximum; straight after reset
    // nothing has been seen, so it must give seen, time, offset and complete. It is
    // followed by a clear carrying a stray last flag, a lone byte with the wrong table id
    // that ends at once, and a header with the syntax bits set.
    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{1'b0, 8'hC5, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'h30, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'h0B, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hE0, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hFF, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hFF, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hFF, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hFF, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hFF, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'h00, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'h00, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hFF, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'h55, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hAA, 1'b1,  4, KIND_SEEN},
        '{1'b1, 8'hFF, 1'b1,  0, KIND_SEEN},
        '{1'b0, 8'h3A, 1'b1,  0, KIND_SEEN},
        '{1'b0, 8'hC5, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'hC0, 1'b0, -1, KIND_SEEN},
        '{1'b0, 8'h0B, 1'b1,  0, KIND_SEEN}
    };

    // Predictor copy of the registers.
    logic [7:0]  cfg_match_id;
    logic        cfg_notify;

    // Predictor copy of the parser and of the stored values.
    logic [12:0] cur_pos;
    logic [11:0] sec_len;
    logic        sec_bad;
    phase_t      walk_phase;
    logic [7:0]  desc_tag;
    logic [7:0]  desc_left;
    logic [7:0]  desc_first;
    logic [31:0] got_time;
    logic [7:0]  got_offset;
    logic [14:0] got_dst;
    logic [31:0] held_time;
    logic [7:0]  held_offset;
    logic [14:0] held_dst;

    // Notices that the block still owes, oldest first.
    notice_t pending_notices [$];

    int  mismatches;
    int  notices_seen;
    int  items_sent;
    int  cycle_count;
    int  stall_left;
    bit  quiet;

    // Section image built by the random part, and the values of the last one built so
    // that later sections can repeat them and so give no change.
    logic [7:0]  sec_img [0:255];
    int          sec_total;
    logic [31:0] last_time;
    logic [7:0]  last_offset;
    logic [7:0]  last_dst_first;
    logic [7:0]  last_dst_hour;

    always #(CLK_HALF) clk = ~clk;

    task automatic report_mismatch(input string msg);
        begin
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        end
    endtask

    task automatic clear_parser();
        begin
            cur_pos    = '0;
            sec_len    = '0;
            sec_bad    = 1'b0;
            walk_phase = PH_TAG;
            desc_tag   = '0;
            desc_left  = '0;
            desc_first = '0;
            got_time   = '0;
            got_offset = '0;
            got_dst    = '0;
        end
    endtask

    function automatic notice_t make_notice(input kind_t k);
        notice_t m;
        begin
            m.kind   = k;
            m.tval   = (k == KIND_TIME) ? got_time : 32'd0;
            m.oval   = (k == KIND_OFFSET) ? got_offset : 8'd0;
            m.known  = (k == KIND_DST) ? got_dst[14] : 1'b0;
            m.active = (k == KIND_DST) ? got_dst[13] : 1'b0;
            m.day    = (k == KIND_DST) ? got_dst[12:8] : 5'd0;
            m.hour   = (k == KIND_DST) ? got_dst[7:0] : 8'd0;
            m.fin    = 1'b0;
            return m;
        end
    endfunction

    // Works out what one accepted item does to the parser and queues the notices that it
    // causes. The count and the first kind are handed back for the directed table.
    task automatic predict_section_byte(input bit func, input logic [7:0] b, input bit last,
                                        output int n, output kind_t first);
        int      p;
        int      end_pos;
        bit      changed;
        notice_t run [$];
        begin
            n = 0;
            first = KIND_SEEN;
            changed = 1'b0;
            if (func) begin
                clear_parser();
                held_time   = '0;
                held_offset = '0;
                held_dst    = '0;
            end
            else begin
                p = int'(cur_pos);
                if (p >= MAX_SECTION_BYTES) begin
                    sec_bad = 1'b1;
                end
                else if (!sec_bad) begin
                    if (p == 0) begin
                        if (b != cfg_match_id) sec_bad = 1'b1;
                    end
                    else if (p == 1) begin
                        if ((b & 8'hC0) != 8'h00) sec_bad = 1'b1;
                        sec_len = {b[3:0], 8'h00};
                    end
                    else if (p == 2) begin
                        sec_len[7:0] = b;
                        if (sec_len < MIN_LENGTH) sec_bad = 1'b1;
                    end
                    else if (p == 3) begin
                        if (b[4:0] != 5'd0) sec_bad = 1'b1;
                    end
                    else if (p <= 7) begin
                        got_time = {got_time[23:0], b};
                    end
                    else if (p == 8) begin
                        got_offset = b;
                    end
                    else begin
                        // Descriptor loop, which stops short of the first CRC byte.
                        end_pos = int'(sec_len) - 1;
                        if (p >= WALK_START && p < end_pos) begin
                            case (walk_phase)
                                PH_TAG: begin
                                    if (p + 1 < end_pos) begin
                                        desc_tag   = b;
                                        walk_phase = PH_LEN;
                                    end
                                end
                                PH_LEN: begin
                                    desc_left = b;
                                    if (p + 1 + int'(b) > end_pos)
                                        sec_bad = 1'b1;
                                    else if (desc_tag == DST_TAG && b != DST_LENGTH)
                                        sec_bad = 1'b1;
                                    else
                                        walk_phase = (b == 8'd0) ? PH_TAG : PH_BODY;
                                end
                                default: begin
                                    if (desc_tag == DST_TAG) begin
                                        if (desc_left == 8'd2)
                                            desc_first = b;
                                        else if (desc_left == 8'd1)
                                            got_dst = {1'b1, desc_first[7], desc_first[4:0], b};
                                    end
                                    desc_left = desc_left - 8'd1;
                                    if (desc_left == 8'd0) walk_phase = PH_TAG;
                                end
                            endcase
                        end
                    end
                end
                if (p < MAX_SECTION_BYTES) cur_pos = 13'(p + 1);

                if (last) begin
                    if (!sec_bad && p < MAX_SECTION_BYTES && p == int'(sec_len) + 2) begin
                        if (cfg_notify) begin
                            if (got_time != held_time) begin
                                run.push_back(make_notice(held_time == 32'd0 ?
                                                          KIND_SEEN : KIND_CHANGED));
                                changed = 1'b1;
                                run.push_back(make_notice(KIND_TIME));
                            end
                            if (got_offset != held_offset) begin
                                if (!changed) run.push_back(make_notice(KIND_CHANGED));
                                changed = 1'b1;
                                run.push_back(make_notice(KIND_OFFSET));
                            end
                            // The known bit is stored but takes no part in the comparison.
                            if (got_dst[13:0] != held_dst[13:0]) begin
                                if (!changed) run.push_back(make_notice(KIND_CHANGED));
                                changed = 1'b1;
                                run.push_back(make_notice(KIND_DST));
                            end
                            if (changed) run.push_back(make_notice(KIND_COMPLETE));
                            if (run.size() > 0) begin
                                run[run.size() - 1].fin = 1'b1;
                                n = run.size();
                                first = run[0].kind;
                                foreach (run[i]) pending_notices.push_back(run[i]);
                            end
                        end
                        held_time   = got_time;
                        held_offset = got_offset;
                        held_dst    = got_dst;
                    end
                    clear_parser();
                end
            end
        end
    endtask

    task automatic check_notice();
        notice_t want;
        begin
            if (pending_notices.size() == 0) begin
                report_mismatch($sformatf("notice of kind %0d with nothing pending",
                                          notice_if.kind));
            end
            else begin
                want = pending_notices.pop_front();
                notices_seen++;
                if (notice_if.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d",
                                              notice_if.kind, want.kind));
                if (notice_if.time_value !== want.tval)
                    report_mismatch($sformatf("time_value %h, wanted %h",
                                              notice_if.time_value, want.tval));
                if (notice_if.offset_value !== want.oval)
                    report_mismatch($sformatf("offset_value %h, wanted %h",
                                              notice_if.offset_value, want.oval));
                if (notice_if.dst_known !== want.known)
                    report_mismatch($sformatf("dst_known %b, wanted %b",
                                              notice_if.dst_known, want.known));
                if (notice_if.dst_active !== want.active)
                    report_mismatch($sformatf("dst_active %b, wanted %b",
                                              notice_if.dst_active, want.active));
                if (notice_if.dst_day !== want.day)
                    report_mismatch($sformatf("dst_day %0d, wanted %0d",
                                              notice_if.dst_day, want.day));
                if (notice_if.dst_hour !== want.hour)
                    report_mismatch($sformatf("dst_hour %0d, wanted %0d",
                                              notice_if.dst_hour, want.hour));
                if (notice_if.final_notice !== want.fin)
                    report_mismatch($sformatf("final_notice %b, wanted %b",
                                              notice_if.final_notice, want.fin));
            end
        end
    endtask

    // Most gaps are short, a few are long, and quiet stretches have none at all.
    function automatic int idle_length();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (quiet || r < 60) return 0;
            if (r < 90) return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
    endfunction

    // Offers one item, waits for the handshake, predicts its effect and then perhaps idles.
    // The valid is left high when the next item follows straight away.
    task automatic send_byte(input bit func, input logic [7:0] b, input bit last,
                             output int n, output kind_t first);
        int gap;
        begin
            byte_if.valid     <= 1'b1;
            byte_if.func      <= func;
            byte_if.data_byte <= b;
            byte_if.last_byte <= last;
            @(posedge clk);
            while (!byte_if.ready) @(posedge clk);
            predict_section_byte(func, b, last, n, first);
            items_sent++;
            gap = idle_length();
            if (gap > 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Holds the sender off until every notice owed has come, then lets the block settle,
    // since the last items may have caused nothing that could be waited for.
    task automatic wait_drained();
        begin
            byte_if.valid <= 1'b0;
            while (pending_notices.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Both registers are written on back-to-back cycles, only while the block is idle.
    task automatic apply_settings(input logic [7:0] match_id, input logic notify);
        begin
            wait_drained();
            cfg_write <= 1'b1;
            cfg_index <= CFG_MATCH_ID;
            cfg_data  <= match_id;
            @(posedge clk);
            cfg_index <= CFG_NOTIFY;
            cfg_data  <= {7'd0, notify};
            @(posedge clk);
            cfg_write <= 1'b0;
            cfg_match_id = match_id;
            cfg_notify   = notify;
            @(posedge clk);
        end
    endtask

    // Builds one section image. Values are often reused from the previous section so that
    // both changed and unchanged runs occur, and one flaw at most is put in.
    task automatic build_section(input flaw_t flaw);
        int         len;
        int         end_pos;
        int         p;
        int         room;
        int         body;
        int         dst_left;
        int         r;
        bit         spoilt;
        logic [7:0] tag;
        begin
            if (flaw == FL_SHORT_LEN)
                len = $urandom_range(0, MIN_LENGTH - 1);
            else if (flaw == FL_DST_LEN || flaw == FL_OVERRUN)
                len = $urandom_range(24, 40);
            else if ($urandom_range(0, 99) < 85)
                len = $urandom_range(MIN_LENGTH, 34);
            else
                len = $urandom_range(35, 120);

            sec_total = len + 3;
            if (flaw == FL_EARLY_END) sec_total -= $urandom_range(1, 3);
            if (flaw == FL_LATE_END) sec_total += $urandom_range(1, 3);

            for (int k = 0; k < 256; k++) sec_img[k] = 8'($urandom_range(0, 255));

            // Header: table id, syntax bits and length, protocol version.
            sec_img[0] = (flaw == FL_BAD_ID) ?
                         cfg_match_id ^ 8'($urandom_range(1, 255)) : cfg_match_id;
            sec_img[1] = {(flaw == FL_SYNTAX) ? 2'($urandom_range(1, 3)) : 2'b00,
                          2'($urandom_range(0, 3)), 4'(len >> 8)};
            sec_img[2] = 8'(len);
            sec_img[3] = {3'($urandom_range(0, 7)),
                          (flaw == FL_VERSION) ? 5'($urandom_range(1, 31)) : 5'd0};

            r = $urandom_range(0, 99);
            if (r < 30)      last_time = last_time;
            else if (r < 40) last_time = 32'd0;
            else if (r < 50) last_time = 32'hFFFF_FFFF;
            else if (r < 65) last_time = last_time + 32'd1;
            else             last_time = $urandom;
            {sec_img[4], sec_img[5], sec_img[6], sec_img[7]} = last_time;
            if ($urandom_range(0, 1)) last_offset = 8'($urandom_range(0, 255));
            sec_img[8] = last_offset;

            // Descriptor loop. Several daylight descriptors may appear; the last one counts.
            if (flaw == FL_DST_LEN)
                dst_left = 1;
            else
                dst_left = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 2) : 0;
            end_pos = len - 1;
            p = WALK_START;
            spoilt = 1'b0;
            while (!spoilt && p + 1 < end_pos) begin
                room = end_pos - p - 2;
                if (flaw == FL_OVERRUN) begin
                    tag = 8'($urandom_range(0, 255));
                    body = room + 1 + $urandom_range(0, 3);
                    spoilt = 1'b1;
                end
                else if (dst_left > 0 && room >= 2) begin
                    tag = DST_TAG;
                    body = 2;
                    dst_left--;
                    if (flaw == FL_DST_LEN) begin
                        body = (room >= 3 && $urandom_range(0, 1)) ? 3 : $urandom_range(0, 1);
                        spoilt = 1'b1;
                    end
                end
                else begin
                    tag = 8'($urandom_range(0, 255));
                    if (tag == DST_TAG) tag = tag ^ 8'h01;
                    body = $urandom_range(0, (room < 5) ? room : 5);
                end
                sec_img[p]     = tag;
                sec_img[p + 1] = 8'(body);
                if (!spoilt && tag == DST_TAG) begin
                    if ($urandom_range(0, 1)) begin
                        last_dst_first = sec_img[p + 2];
                        last_dst_hour  = sec_img[p + 3];
                    end
                    sec_img[p + 2] = last_dst_first;
                    sec_img[p + 3] = last_dst_hour;
                end
                p += 2 + body;
            end
        end
    endtask

    task automatic send_image();
        int    n;
        kind_t first;
        begin
            for (int k = 0; k < sec_total; k++)
                send_byte(1'b0, sec_img[k], k == sec_total - 1, n, first);
        end
    endtask

    // A short burst of loose items: clears, stray bytes and stray last flags.
    task automatic send_noise();
        int    cnt;
        int    n;
        kind_t first;
        bit    last;
        begin
            cnt = $urandom_range(1, 4);
            for (int k = 0; k < cnt; k++) begin
                last = (k == cnt - 1) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0);
                send_byte($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)), last,
                          n, first);
            end
        end
    endtask

    // A section longer than the parser will count: the position stops at the limit and
    // the final byte must be dropped without notices.
    task automatic send_overlong();
        int    n;
        kind_t first;
        begin
            quiet = 1'b1;
            for (int k = 0; k < OVERLONG_BYTES; k++)
                send_byte(1'b0, (k == 0) ? cfg_match_id : 8'($urandom_range(0, 255)),
                          k == OVERLONG_BYTES - 1, n, first);
            quiet = 1'b0;
        end
    endtask

    // Receiving side: checks each accepted notice against the oldest one owed, and stalls
    // ready at random. Stalls are mostly short with the occasional long one. The cycle
    // counter also lives here and ends a run that has hung.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d notices pending", $time, pending_notices.size());
            $display("*** FAILED ***");
            $finish;
        end
        else if (rst_n) begin
            if (notice_if.valid && notice_if.ready) check_notice();
            if (stall_left > 0) begin
                notice_if.ready <= 1'b0;
                stall_left--;
            end
            else begin
                notice_if.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 25) begin
                    if ($urandom_range(0, 99) < 75)      stall_left = $urandom_range(1, 2);
                    else if ($urandom_range(0, 99) < 80) stall_left = $urandom_range(3, 6);
                    else                                 stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : stimulus
        int    n;
        kind_t first;
        int    target;
        int    sections;
        int    flaw_pick;
        int    r;
        flaw_t flaw;
        logic [7:0] phase_tid [0:PHASE_COUNT-1];
        logic       phase_ntf [0:PHASE_COUNT-1];

        // Every input is at a known level from time zero, and reset is held from the start.
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = CFG_MATCH_ID;
        cfg_data            = 8'd0;
        byte_if.valid       = 1'b0;
        byte_if.func        = 1'b0;
        byte_if.data_byte   = 8'd0;
        byte_if.last_byte   = 1'b0;
        notice_if.ready     = 1'b0;
        mismatches          = 0;
        notices_seen        = 0;
        items_sent          = 0;
        cycle_count         = 0;
        stall_left          = 0;
        quiet               = 1'b0;
        sections            = 0;
        flaw_pick           = 0;
        last_time           = 32'd0;
        last_offset         = 8'd0;
        last_dst_first      = 8'd0;
        last_dst_hour       = 8'd0;
        cfg_match_id        = 8'd197;
        cfg_notify          = 1'b1;
        held_time           = '0;
        held_offset         = '0;
        held_dst            = '0;
        clear_parser();

        // Register settings of the random phases, the extremes of both registers included.
        phase_tid[0] = 8'd0;    phase_ntf[0] = 1'b1;
        phase_tid[1] = 8'd255;  phase_ntf[1] = 1'b0;
        phase_tid[2] = 8'($urandom_range(1, 254)); phase_ntf[2] = 1'b1;
        phase_tid[3] = 8'd197;  phase_ntf[3] = 1'b1;
        phase_tid[4] = 8'd255;  phase_ntf[4] = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run on the reset values of the registers.
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].func, directed_rows[i].data, directed_rows[i].last,
                      n, first);
            if (directed_rows[i].want_n >= 0 &&
                (n != directed_rows[i].want_n ||
                 (n > 0 && first != directed_rows[i].want_first)))
                report_mismatch($sformatf("directed row %0d gives %0d notices from kind %0d",
                                          i, n, first));
        end

        // Random part, in phases with different register settings. Each flaw is tried
        // once at the start, after which most sections are well formed.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            apply_settings(phase_tid[ph], phase_ntf[ph]);
            last_time = 32'd0;
            target = (ph + 1) * ITEM_TARGET / PHASE_COUNT;
            if (ph == 3) send_overlong();
            while (items_sent < target + OVERLONG_BYTES * (ph >= 3) + DIRECTED_ROWS
                   || (ph == PHASE_COUNT - 1 && notices_seen < NOTICE_TARGET)) begin
                quiet = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_noise();
                end
                else begin
                    if (flaw_pick < FL_COUNT) begin
                        flaw = flaw_t'(flaw_pick);
                        flaw_pick++;
                    end
                    else if ($urandom_range(0, 99) < 70)
                        flaw = FL_NONE;
                    else
                        flaw = flaw_t'($urandom_range(1, FL_COUNT - 1));
                    build_section(flaw);
                    send_image();
                end
                sections++;
                // Now and then the sender waits for the emitter to empty completely.
                if (sections % 7 == 0) wait_drained();
            end
        end
        quiet = 1'b0;

        // Wind-down: everything owed must arrive, and nothing more may follow it.
        wait_drained();
        if (pending_notices.size() != 0)
            report_mismatch($sformatf("%0d notices never came", pending_notices.size()));

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
